FILE: sv/dmkt_pkg.sv
package dmkt_pkg;

    localparam int KEY_W   = 64;
    localparam int SCORE_W = 16;
    localparam int MOVE_W  = 16;
    localparam int DEPTH_W = 8;
    localparam int KIND_W  = 2;
    localparam int CFG_W   = 17;
    localparam int HALF_W  = KEY_W / 2;
    localparam int PROD_W  = HALF_W + CFG_W;
    localparam logic [CFG_W-1:0] CFG_RESET = 17'd65536;
    localparam int CFG_MAX = (1 << CFG_W) - 1;

    typedef enum logic [1:0] {
        REQ_STORE  = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req_type;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]         move;
        logic [DEPTH_W-1:0]        depth;
        logic [KIND_W-1:0]         kind;
    } t_entry;

    typedef struct packed {
        logic [1:0] req_type;
        t_entry     entry;
    } t_req;

    typedef struct packed {
        logic   hit;
        logic   clear_done;
        t_entry entry;
    } t_rsp;

    typedef struct packed {
        logic load_req;
        logic calc_addr;
        logic mem_we;
        logic wr_zero;
        logic mem_re;
        logic ptr_clr;
        logic ptr_inc;
        logic load_lookup;
        logic load_clear;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic       init_end;
        logic       clear_end;
    } t_sts;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ADDR,
        S_WRITE,
        S_READ,
        S_LOAD,
        S_CLEAR,
        S_RESP
    } t_state;

endpackage

FILE: sv/dmkt_if.sv
interface dmkt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [63:0]        key;
    logic signed [15:0] score;
    logic [15:0]        move_code;
    logic [7:0]         search_depth;
    logic [1:0]         node_kind;

    modport source (output valid, req_type, key, score, move_code, search_depth, node_kind,
                    input ready);
    modport sink   (input valid, req_type, key, score, move_code, search_depth, node_kind,
                    output ready);
endinterface

interface dmkt_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic               clear_done;
    logic [63:0]        entry_key;
    logic signed [15:0] entry_score;
    logic [15:0]        entry_move;
    logic [7:0]         entry_depth;
    logic [1:0]         entry_kind;

    modport source (output valid, hit, clear_done, entry_key, entry_score, entry_move,
                    entry_depth, entry_kind, input ready);
    modport sink   (input valid, hit, clear_done, entry_key, entry_score, entry_move,
                    entry_depth, entry_kind, output ready);
endinterface

FILE: sv/dmkt_datapath.sv
module dmkt_datapath #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dmkt_pkg::t_req                i_req,
    input  dmkt_pkg::t_cmd                i_cmd,
    input  logic                          i_cfg_we,
    input  logic [dmkt_pkg::CFG_W-1:0]    i_cfg_data,
    output dmkt_pkg::t_sts                o_sts,
    output dmkt_pkg::t_rsp                o_rsp
);
    import dmkt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [CFG_W-1:0] N_CAP =
        CFG_W'((TABLE_DEPTH > CFG_MAX) ? CFG_MAX : TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

    logic [CFG_W-1:0]  r_table_entries;
    logic [CFG_W-1:0]  n_in_use;
    logic [CFG_W-1:0]  n_last;
    logic [1:0]        r_type;
    t_entry            r_req;
    logic [PROD_W-1:0] r_lo_prod;
    logic [PROD_W-1:0] r_hi_prod;
    logic [PROD_W:0]   n_mid;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_ptr;
    logic [AW-1:0]     n_waddr;
    t_entry            n_wdata;
    t_entry            r_rdata;
    t_rsp              r_out;
    t_entry            mem [TABLE_DEPTH];

    // Saturate the entry count to [1, TABLE_DEPTH].
    always_comb begin
        if (r_table_entries == '0) begin
            n_in_use = CFG_W'(1);
        end else if (r_table_entries > N_CAP) begin
            n_in_use = N_CAP;
        end else begin
            n_in_use = r_table_entries;
        end
        n_last = n_in_use - CFG_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_entries <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_table_entries <= i_cfg_data;
        end
    end

    // Capture request, form both 32 x 17 partial products.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_type    <= i_req.req_type;
            r_req     <= i_req.entry;
            r_lo_prod <= i_req.entry.key[HALF_W-1:0] * n_in_use;
            r_hi_prod <= i_req.entry.key[KEY_W-1:HALF_W] * n_in_use;
        end
    end

    // Upper word of key * n: slot index, always below n.
    assign n_mid = {1'b0, r_hi_prod} + (PROD_W + 1)'(r_lo_prod[PROD_W-1:HALF_W]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_addr) begin
            r_addr <= AW'(n_mid[PROD_W:HALF_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_cmd.ptr_clr) begin
            r_ptr <= '0;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + AW'(1);
        end
    end

    assign n_waddr = i_cmd.wr_zero ? r_ptr : r_addr;
    assign n_wdata = i_cmd.wr_zero ? '0 : r_req;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            mem[n_waddr] <= n_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_re) begin
            r_rdata <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_lookup) begin
            r_out.hit        <= (r_rdata.key == r_req.key);
            r_out.clear_done <= 1'b0;
            r_out.entry      <= r_rdata;
        end else if (i_cmd.load_clear) begin
            r_out.hit        <= 1'b0;
            r_out.clear_done <= 1'b1;
            r_out.entry      <= '0;
        end
    end

    assign o_sts.req_type  = r_type;
    assign o_sts.init_end  = (r_ptr == LAST_SLOT);
    assign o_sts.clear_end = (r_ptr == AW'(n_last));
    assign o_rsp           = r_out;

    a_clear_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_clear |=> (r_out.clear_done && !r_out.hit && r_out.entry == '0))
        else $error("clear word carries nonzero payload");
    a_store_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mem_we && !i_cmd.wr_zero) |-> (r_type == REQ_STORE))
        else $error("slot write outside a store request");

endmodule

FILE: sv/dmkt_ctrl.sv
module dmkt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  dmkt_pkg::t_sts i_sts,
    output dmkt_pkg::t_cmd o_cmd
);
    import dmkt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.mem_we  = 1'b1;
                o_cmd.wr_zero = 1'b1;
                o_cmd.ptr_inc = 1'b1;
                if (i_sts.init_end) begin
                    o_cmd.ptr_clr = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load_req = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                o_cmd.calc_addr = 1'b1;
                case (i_sts.req_type)
                    REQ_STORE:  n_state = S_WRITE;
                    REQ_LOOKUP: n_state = S_READ;
                    REQ_CLEAR: begin
                        o_cmd.ptr_clr = 1'b1;
                        n_state       = S_CLEAR;
                    end
                    default:    n_state = S_IDLE;
                endcase
            end
            S_WRITE: begin
                o_cmd.mem_we = 1'b1;
                n_state      = S_IDLE;
            end
            S_READ: begin
                o_cmd.mem_re = 1'b1;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_lookup = 1'b1;
                n_state           = S_RESP;
            end
            S_CLEAR: begin
                o_cmd.mem_we  = 1'b1;
                o_cmd.wr_zero = 1'b1;
                o_cmd.ptr_inc = 1'b1;
                if (i_sts.clear_end) begin
                    o_cmd.ptr_clr    = 1'b1;
                    o_cmd.load_clear = 1'b1;
                    n_state          = S_RESP;
                end
            end
            S_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output open together");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_ADDR))
        else $error("accepted word not taken into work");
    a_clear_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && !i_sts.clear_end) |=> (r_state == S_CLEAR))
        else $error("clear walk left early");
    a_resp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(o_cmd.load_lookup) || $past(o_cmd.load_clear)))
        else $error("result shown without a load");

endmodule

FILE: sv/direct_mapped_keyed_table_top.sv
// Channel   Dir  Handshake              Word
// i_req     in   i_req.valid/ready      req_type, key, score, move_code, search_depth, node_kind
// o_rsp     out  o_rsp.valid/ready      hit, clear_done, entry_key/score/move/depth/kind
// cfg       in   i_cfg_we (no ready)    i_cfg_data = table_entries
//
// Sequence: one word in work at a time. Store runs S_ADDR, S_WRITE, then ready again; lookup S_ADDR,
//   S_READ, S_LOAD, S_RESP plus output stall (address multiply, index add, registered memory read,
//   compare); clear S_ADDR, S_CLEAR, S_RESP plus output stall, slots in use zeroed one per cycle on the write port.
// Reset: synchronous, active low; afterwards a clearing pass zeroes all TABLE_DEPTH slots,
//   one per cycle, with i_req.ready low until the pass ends.
// Stalls: o_rsp.valid holds its word until o_rsp.ready; no input is taken meanwhile.
module direct_mapped_keyed_table_top #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    dmkt_req_if.sink                   i_req,
    dmkt_rsp_if.source                 o_rsp,
    input  logic                       i_cfg_we,
    input  logic [dmkt_pkg::CFG_W-1:0] i_cfg_data
);
    import dmkt_pkg::*;

    t_req req_word;
    t_rsp rsp_word;
    t_cmd cmd;
    t_sts sts;

    // Gather the input word into one struct for the datapath.
    assign req_word.req_type     = i_req.req_type;
    assign req_word.entry.key    = i_req.key;
    assign req_word.entry.score  = i_req.score;
    assign req_word.entry.move   = i_req.move_code;
    assign req_word.entry.depth  = i_req.search_depth;
    assign req_word.entry.kind   = i_req.node_kind;

    // Controller: sequences init pass, index, access, clear walk and result hold.
    dmkt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: entry count register, index multiply, slot memory, result register.
    dmkt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_word),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_sts      (sts),
        .o_rsp      (rsp_word)
    );

    // Spread the result register onto the output channel.
    assign o_rsp.hit         = rsp_word.hit;
    assign o_rsp.clear_done  = rsp_word.clear_done;
    assign o_rsp.entry_key   = rsp_word.entry.key;
    assign o_rsp.entry_score = rsp_word.entry.score;
    assign o_rsp.entry_move  = rsp_word.entry.move;
    assign o_rsp.entry_depth = rsp_word.entry.depth;
    assign o_rsp.entry_kind  = rsp_word.entry.kind;

endmodule

FILE: verif/dmkt_tb_checker.sv
`timescale 1ns / 1ps

module dmkt_tb_checker #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    dmkt_req_if                        req,
    dmkt_rsp_if                        rsp,
    input  logic                       i_cfg_we,
    input  logic [dmkt_pkg::CFG_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    import dmkt_pkg::*;

    t_entry           slot_mem [TABLE_DEPTH];
    logic [CFG_W-1:0] entries_reg;
    t_rsp             awaited_rsp [$];
    int               mismatch_count = 0;
    int               awaited_count  = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = awaited_count;

    function automatic int unsigned entries_in_use();
        int unsigned n;
        n = 32'(entries_reg);
        if (n == 0) n = 1;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        return n;
    endfunction

    // upper 64 bits of key * n
    function automatic int unsigned slot_of(input logic [KEY_W-1:0] key, input int unsigned n);
        logic [127:0] prod;
        prod = {64'd0, key} * {96'd0, n};
        return prod[95:64];
    endfunction

    function automatic void apply_request(input logic [1:0] kind, input t_entry word);
        int unsigned n;
        int unsigned slot;
        t_rsp        reply;
        n    = entries_in_use();
        slot = slot_of(word.key, n);
        if (slot >= TABLE_DEPTH) slot = TABLE_DEPTH - 1;
        case (kind)
            REQ_STORE: begin
                slot_mem[slot] = word;
            end
            REQ_LOOKUP: begin
                reply.hit        = (slot_mem[slot].key == word.key);
                reply.clear_done = 1'b0;
                reply.entry      = slot_mem[slot];
                awaited_rsp.push_back(reply);
            end
            REQ_CLEAR: begin
                for (int unsigned i = 0; i < n; i++) slot_mem[i] = '0;
                reply            = '0;
                reply.clear_done = 1'b1;
                awaited_rsp.push_back(reply);
            end
            default: ;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_entry word;
        t_rsp   want;
        if (!i_rst_n) begin
            entries_reg = CFG_RESET;
            for (int i = 0; i < TABLE_DEPTH; i++) slot_mem[i] = '0;
        end else begin
            if (i_cfg_we) entries_reg = i_cfg_data;
            // compare first: only one word is in work, so a reply never belongs
            // to a request accepted at the same edge
            if (rsp.valid && rsp.ready) begin
                if (awaited_rsp.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: reply with nothing awaited, expected none, actual key %0h",
                             $time, rsp.entry_key);
                end else begin
                    want = awaited_rsp.pop_front();
                    check_field("hit", 64'(want.hit), 64'(rsp.hit));
                    check_field("clear_done", 64'(want.clear_done), 64'(rsp.clear_done));
                    check_field("entry_key", want.entry.key, rsp.entry_key);
                    check_field("entry_score", 64'(want.entry.score), 64'(rsp.entry_score));
                    check_field("entry_move", 64'(want.entry.move), 64'(rsp.entry_move));
                    check_field("entry_depth", 64'(want.entry.depth), 64'(rsp.entry_depth));
                    check_field("entry_kind", 64'(want.entry.kind), 64'(rsp.entry_kind));
                end
            end
            if (req.valid && req.ready) begin
                word.key   = req.key;
                word.score = req.score;
                word.move  = req.move_code;
                word.depth = req.search_depth;
                word.kind  = req.node_kind;
                apply_request(req.req_type, word);
            end
        end
        awaited_count = awaited_rsp.size();
    end

endmodule

FILE: verif/direct_mapped_keyed_table_top_tb.sv
`timescale 1ns / 1ps

module direct_mapped_keyed_table_top_tb;
    import dmkt_pkg::*;

    localparam int          TABLE_DEPTH     = 65536;
    localparam int          WORDS_PER_PHASE = 140;
    // settle time after the last reply: covers a trailing store
    localparam int          SETTLE_CYCLES   = 16;
    localparam logic [1:0]  REQ_UNUSED      = 2'd3;
    localparam logic [63:0] KEY_ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] KEY_HALF        = 64'h8000_0000_0000_0000;
    // small counts get random clears; large ones only the directed ones
    localparam int          CLEAR_LIMIT     = 1024;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_cfg_we   = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    // calm turns off idling on both sides for one whole phase
    bit          calm = 1'b0;
    int          fail_count;
    int          pending;
    int unsigned entries_now = TABLE_DEPTH;
    int          words_sent;
    logic [63:0] key_pool [64];
    int          pool_used = 0;

    dmkt_req_if req_bus ();
    dmkt_rsp_if rsp_bus ();

    direct_mapped_keyed_table_top #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    dmkt_tb_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req_bus),
        .rsp          (rsp_bus),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    // Hard stop. The slowest correct run is the clearing pass after reset, two
    // full-size clears and ~1700 words with stalls; the stop lies well beyond it.
    initial begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: drop ready about 26 percent of the time, except in the calm phase.
    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_bus.ready <= calm || ($urandom_range(99) >= 26);
        end
    end

    // Present one word, hold it until accepted, then maybe idle for a while.
    // Valid stays high into the next word unless a gap is taken, so it is
    // never lowered and raised in the same step.
    task automatic send_word(input logic [1:0] kind, input logic [63:0] key,
                             input logic [15:0] score, input logic [15:0] move,
                             input logic [7:0] depth, input logic [1:0] node);
        req_bus.valid        <= 1'b1;
        req_bus.req_type     <= kind;
        req_bus.key          <= key;
        req_bus.score        <= score;
        req_bus.move_code    <= move;
        req_bus.search_depth <= depth;
        req_bus.node_kind    <= node;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (kind != REQ_UNUSED) words_sent++;
        if (!calm && $urandom_range(99) < 26) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    // Lower valid and hold the sender until every awaited reply is back.
    task automatic drain_replies();
        req_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // Write the entry count only with the block idle: drain, let a trailing
    // store finish, then pulse the write enable for one cycle.
    task automatic set_entries(input int unsigned value);
        drain_replies();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        entries_now = (value == 0) ? 1 : (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
        words_sent  = 0;
    endtask

    // Mostly stores and lookups on recently stored keys so that hits, misses
    // on shared slots and overwrites all happen; a few unused types as noise.
    task automatic send_random_word();
        int unsigned pick;
        int unsigned pick_key;
        logic [1:0]  kind;
        logic [63:0] key;
        pick     = $urandom_range(999);
        pick_key = $urandom_range(99);
        if (pick < 30) kind = REQ_UNUSED;
        else if (pick < 50 && entries_now <= CLEAR_LIMIT) kind = REQ_CLEAR;
        else if (pick < 520) kind = REQ_STORE;
        else kind = REQ_LOOKUP;

        if (pick_key < 55 && pool_used > 0) key = key_pool[$urandom_range(pool_used - 1)];
        else if (pick_key < 58) key = '0;
        else if (pick_key < 61) key = KEY_ALL_ONES;
        else key = {$urandom, $urandom};

        if (kind == REQ_STORE) begin
            if (pool_used < 64) key_pool[pool_used++] = key;
            else key_pool[$urandom_range(63)] = key;
        end
        // now and then hold the sender until every reply is back
        if ($urandom_range(199) == 0) drain_replies();
        send_word(kind, key, 16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                  8'($urandom_range(8'hFF)), 2'($urandom_range(3)));
    endtask

    task automatic run_random_phase();
        while (words_sent < WORDS_PER_PHASE) send_random_word();
    endtask

    initial begin
        int unsigned phase_entries [11];
        phase_entries = '{1024, 16, 1024, 0, 1, 2, 3, 1000, 131071, 65535, 0};
        phase_entries[10] = $urandom_range(4, 300);

        // drive every input to a known value before the first edge
        req_bus.valid        = 1'b0;
        req_bus.req_type     = REQ_STORE;
        req_bus.key          = '0;
        req_bus.score        = '0;
        req_bus.move_code    = '0;
        req_bus.search_depth = '0;
        req_bus.node_kind    = '0;

        // hold reset, then release it at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words at the reset count (all slots in use).
        // Extreme keys land on the first and last slot.
        send_word(REQ_STORE, '0, 16'h8000, 16'h0000, 8'h00, 2'd0);
        send_word(REQ_STORE, KEY_ALL_ONES, 16'h7FFF, 16'hFFFF, 8'hFF, 2'd3);
        send_word(REQ_LOOKUP, '0, 16'h1234, 16'h5678, 8'h9A, 2'd1);
        send_word(REQ_LOOKUP, KEY_ALL_ONES, 16'h0, 16'h0, 8'h0, 2'd0);
        // same slot as key zero, different key: miss with the stored contents
        send_word(REQ_LOOKUP, 64'd1, 16'hFFFF, 16'hFFFF, 8'hFF, 2'd3);
        // mid-table slot, never written: miss on a zero entry
        send_word(REQ_LOOKUP, KEY_HALF, 16'h0, 16'h0, 8'h0, 2'd0);
        send_word(REQ_STORE, KEY_HALF, 16'hFFFF, 16'hA5A5, 8'h5A, 2'd2);
        send_word(REQ_LOOKUP, KEY_HALF, 16'h0, 16'h0, 8'h0, 2'd0);
        // unused type: must change nothing and give no reply
        send_word(REQ_UNUSED, KEY_HALF, 16'h0001, 16'h0001, 8'h01, 2'd1);
        send_word(REQ_LOOKUP, KEY_HALF, 16'h0, 16'h0, 8'h0, 2'd0);
        // full-size clear, then a miss on zeros and a hit for the zero key
        send_word(REQ_CLEAR, KEY_ALL_ONES, 16'hFFFF, 16'hFFFF, 8'hFF, 2'd3);
        send_word(REQ_LOOKUP, KEY_ALL_ONES, 16'h0, 16'h0, 8'h0, 2'd0);
        send_word(REQ_LOOKUP, '0, 16'h0, 16'h0, 8'h0, 2'd0);
        drain_replies();

        // random words at the reset count, no clears at this size
        words_sent = 0;
        run_random_phase();

        // Walk the counts: shrink to 16 and back to 1024 so slots beyond the
        // count survive a clear; 0 acts as 1; 131071 saturates.
        foreach (phase_entries[p]) begin
            set_entries(phase_entries[p]);
            calm = (p == 2);
            if (phase_entries[p] == 0) begin
                // every key shares one slot
                send_word(REQ_STORE, 64'h0123_4567_89AB_CDEF, 16'h8001, 16'h00FF, 8'h80,
                          2'd1);
                send_word(REQ_LOOKUP, 64'hFEDC_BA98_7654_3210, 16'h0, 16'h0, 8'h0, 2'd0);
            end
            if (phase_entries[p] > TABLE_DEPTH) begin
                send_word(REQ_STORE, KEY_ALL_ONES, 16'h4000, 16'hBEEF, 8'h7F, 2'd2);
                send_word(REQ_LOOKUP, KEY_ALL_ONES, 16'h0, 16'h0, 8'h0, 2'd0);
                send_word(REQ_CLEAR, '0, 16'h0, 16'h0, 8'h0, 2'd0);
            end
            run_random_phase();
        end
        calm = 1'b0;

        // wait out the last replies and a trailing store, then judge
        drain_replies();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
